FILE: src/dhlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhlt_pkg
// Shared types, constants and helper functions of the DH link transform.
// ----------------------------------------------------------------------------
package dhlt_pkg;

   localparam int CORDIC_STAGES = 24;
   localparam int ANG_W         = 36;   // raw angle in Q6.30 before wrapping
   localparam int CW            = 34;   // cordic x, y and z width

   localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [CW-1:0]    GAIN_Q30    = 34'sd652032874;
   localparam logic signed [63:0]      ROUND_Q30   = 64'sd536870912;
   localparam logic signed [33:0]      SAT_MAX     = 34'sd2147483647;
   localparam logic signed [33:0]      SAT_MIN     = -34'sd2147483648;

   typedef struct packed {
      logic [3:0]         joint_index;
      logic signed [31:0] joint_position;
      logic signed [31:0] angle_offset;
      logic signed [31:0] link_twist;
      logic signed [31:0] link_length;
      logic signed [31:0] link_shift;
   } req_type;

   typedef struct packed {
      logic [3:0]         joint_index_out;
      logic signed [31:0] rot_00;
      logic signed [31:0] rot_01;
      logic signed [31:0] rot_02;
      logic signed [31:0] rot_10;
      logic signed [31:0] rot_11;
      logic signed [31:0] rot_12;
      logic signed [31:0] rot_21;
      logic signed [31:0] rot_22;
      logic signed [31:0] trans_x;
      logic signed [31:0] trans_y;
      logic signed [31:0] trans_z;
   } rsp_type;

   // fields that ride along with the angle path
   typedef struct packed {
      logic [3:0]         joint_index;
      logic signed [31:0] link_length;
      logic signed [31:0] link_shift;
   } side_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      logic                 neg;
   } cord_type;

   function automatic logic signed [CW-1:0] atan_entry(input int unsigned i);
      logic signed [CW-1:0] r;
      case (i)
         0:  r = 34'sd843314856;
         1:  r = 34'sd497837829;
         2:  r = 34'sd263043836;
         3:  r = 34'sd133525158;
         4:  r = 34'sd67021686;
         5:  r = 34'sd33543515;
         6:  r = 34'sd16775850;
         7:  r = 34'sd8388437;
         8:  r = 34'sd4194282;
         9:  r = 34'sd2097149;
         10: r = 34'sd1048575;
         11: r = 34'sd524287;
         12: r = 34'sd262143;
         13: r = 34'sd131071;
         14: r = 34'sd65535;
         15: r = 34'sd32767;
         16: r = 34'sd16383;
         17: r = 34'sd8191;
         18: r = 34'sd4095;
         19: r = 34'sd2047;
         20: r = 34'sd1023;
         21: r = 34'sd511;
         22: r = 34'sd255;
         23: r = 34'sd127;
         24: r = 34'sd63;
         25: r = 34'sd31;
         26: r = 34'sd15;
         27: r = 34'sd7;
         28: r = 34'sd3;
         29: r = 34'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   // input spans at most three turns either way
   function automatic logic signed [ANG_W-1:0] wrap_angle(input logic signed [ANG_W-1:0] z);
      logic signed [ANG_W-1:0] r;
      r = z;
      for (int k = 0; k < 3; k++) begin
         if (r > PI_Q30) begin
            r = r - TWO_PI_Q30;
         end else if (r < -PI_Q30) begin
            r = r + TWO_PI_Q30;
         end
      end
      return r;
   endfunction

   function automatic cord_type fold_angle(input logic signed [ANG_W-1:0] z);
      cord_type r;
      logic signed [ANG_W-1:0] t;
      t     = z;
      r.neg = 1'b0;
      if (z > HALF_PI_Q30) begin
         t     = z - PI_Q30;
         r.neg = 1'b1;
      end else if (z < -HALF_PI_Q30) begin
         t     = z + PI_Q30;
         r.neg = 1'b1;
      end
      r.x = GAIN_Q30;
      r.y = '0;
      r.z = t[CW-1:0];
      return r;
   endfunction

   function automatic cord_type cordic_step(input cord_type a, input int unsigned i);
      cord_type r;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      dx = a.y >>> i;
      dy = a.x >>> i;
      r  = a;
      if (!a.z[CW-1]) begin
         r.x = a.x - dx;
         r.y = a.y + dy;
         r.z = a.z - atan_entry(i);
      end else begin
         r.x = a.x + dx;
         r.y = a.y - dy;
         r.z = a.z + atan_entry(i);
      end
      return r;
   endfunction

   // floor((p + 2^29) / 2^30)
   function automatic logic signed [33:0] round_q30(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + ROUND_Q30;
      return t[63:30];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) begin
         r = 32'sh7fffffff;
      end else if (v < SAT_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: src/dhlt_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhlt_prep
// Angle setup: theta sum, wrap into [-pi, pi], quadrant fold. Three stages.
// ----------------------------------------------------------------------------
module dhlt_prep (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  dhlt_pkg::req_type in_data,
   output logic              out_valid,
   output dhlt_pkg::cord_type out_theta,
   output dhlt_pkg::cord_type out_alpha,
   output dhlt_pkg::side_type out_side
);
   import dhlt_pkg::*;

   logic [2:0]              valid_ff;
   logic signed [ANG_W-1:0] theta_raw_ff, alpha_raw_ff, theta_raw_in, alpha_raw_in;
   logic signed [ANG_W-1:0] theta_wrap_ff, alpha_wrap_ff;
   cord_type                theta_ff, alpha_ff;
   side_type                side0_ff, side1_ff, side2_ff, side_in;
   logic signed [ANG_W-1:0] sum_ext;

   always_comb begin
      sum_ext = {{(ANG_W-32){in_data.joint_position[31]}}, in_data.joint_position}
              + {{(ANG_W-32){in_data.angle_offset[31]}}, in_data.angle_offset};
      theta_raw_in = sum_ext <<< 2;
      alpha_raw_in = {{(ANG_W-32){in_data.link_twist[31]}}, in_data.link_twist} <<< 2;
      side_in.joint_index = in_data.joint_index;
      side_in.link_length = in_data.link_length;
      side_in.link_shift  = in_data.link_shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         theta_raw_ff  <= theta_raw_in;
         alpha_raw_ff  <= alpha_raw_in;
         side0_ff      <= side_in;
         theta_wrap_ff <= wrap_angle(theta_raw_ff);
         alpha_wrap_ff <= wrap_angle(alpha_raw_ff);
         side1_ff      <= side0_ff;
         theta_ff      <= fold_angle(theta_wrap_ff);
         alpha_ff      <= fold_angle(alpha_wrap_ff);
         side2_ff      <= side1_ff;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_theta = theta_ff;
   assign out_alpha = alpha_ff;
   assign out_side  = side2_ff;

endmodule

FILE: src/dhlt_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhlt_cordic
// Two unrolled rotation-mode cordic lanes, one register stage per iteration.
// ----------------------------------------------------------------------------
module dhlt_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               in_valid,
   input  dhlt_pkg::cord_type in_theta,
   input  dhlt_pkg::cord_type in_alpha,
   input  dhlt_pkg::side_type in_side,
   output logic               out_valid,
   output dhlt_pkg::cord_type out_theta,
   output dhlt_pkg::cord_type out_alpha,
   output dhlt_pkg::side_type out_side
);
   import dhlt_pkg::*;

   logic     valid_ff [CORDIC_STAGES];
   cord_type theta_ff [CORDIC_STAGES];
   cord_type alpha_ff [CORDIC_STAGES];
   side_type side_ff  [CORDIC_STAGES];

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      logic     valid_in;
      cord_type theta_in, alpha_in;
      side_type side_in;

      if (i == 0) begin : g_first
         assign valid_in = in_valid;
         assign theta_in = cordic_step(in_theta, 0);
         assign alpha_in = cordic_step(in_alpha, 0);
         assign side_in  = in_side;
      end else begin : g_next
         assign valid_in = valid_ff[i-1];
         assign theta_in = cordic_step(theta_ff[i-1], i);
         assign alpha_in = cordic_step(alpha_ff[i-1], i);
         assign side_in  = side_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (enable) begin
            valid_ff[i] <= valid_in;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            theta_ff[i] <= theta_in;
            alpha_ff[i] <= alpha_in;
            side_ff[i]  <= side_in;
         end
      end
   end

   assign out_valid = valid_ff[CORDIC_STAGES-1];
   assign out_theta = theta_ff[CORDIC_STAGES-1];
   assign out_alpha = alpha_ff[CORDIC_STAGES-1];
   assign out_side  = side_ff[CORDIC_STAGES-1];

endmodule

FILE: src/dhlt_mult.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhlt_mult
// Sign fix of the cordic results, six products, rounding and saturation.
// ----------------------------------------------------------------------------
module dhlt_mult (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               in_valid,
   input  dhlt_pkg::cord_type in_theta,
   input  dhlt_pkg::cord_type in_alpha,
   input  dhlt_pkg::side_type in_side,
   output logic               out_valid,
   output dhlt_pkg::rsp_type  out_data
);
   import dhlt_pkg::*;

   logic [2:0]         valid_ff;
   logic signed [CW-1:0] ct_in, st_in, ca_in, sa_in;
   logic signed [31:0] ct_ff, st_ff, ca_ff, sa_ff;
   logic signed [31:0] ct2_ff, st2_ff, ca2_ff, sa2_ff;
   side_type           side1_ff, side2_ff;
   logic signed [63:0] p_sc_ff, p_ss_ff, p_cc_ff, p_cs_ff, p_lc_ff, p_ls_ff;
   rsp_type            rsp_ff, rsp_in;
   logic signed [33:0] r_sc, r_ss, r_cc, r_cs;

   always_comb begin
      ct_in = in_theta.neg ? -in_theta.x : in_theta.x;
      st_in = in_theta.neg ? -in_theta.y : in_theta.y;
      ca_in = in_alpha.neg ? -in_alpha.x : in_alpha.x;
      sa_in = in_alpha.neg ? -in_alpha.y : in_alpha.y;
   end

   always_comb begin
      r_sc = round_q30(p_sc_ff);
      r_ss = round_q30(p_ss_ff);
      r_cc = round_q30(p_cc_ff);
      r_cs = round_q30(p_cs_ff);
      rsp_in.joint_index_out = side2_ff.joint_index;
      rsp_in.rot_00  = ct2_ff;
      rsp_in.rot_01  = 32'(-r_sc);
      rsp_in.rot_02  = r_ss[31:0];
      rsp_in.rot_10  = st2_ff;
      rsp_in.rot_11  = r_cc[31:0];
      rsp_in.rot_12  = 32'(-r_cs);
      rsp_in.rot_21  = sa2_ff;
      rsp_in.rot_22  = ca2_ff;
      rsp_in.trans_x = sat32(round_q30(p_lc_ff));
      rsp_in.trans_y = sat32(round_q30(p_ls_ff));
      rsp_in.trans_z = side2_ff.link_shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ct_ff    <= ct_in[31:0];
         st_ff    <= st_in[31:0];
         ca_ff    <= ca_in[31:0];
         sa_ff    <= sa_in[31:0];
         side1_ff <= in_side;
         p_sc_ff  <= st_ff * ca_ff;
         p_ss_ff  <= st_ff * sa_ff;
         p_cc_ff  <= ct_ff * ca_ff;
         p_cs_ff  <= ct_ff * sa_ff;
         p_lc_ff  <= side1_ff.link_length * ct_ff;
         p_ls_ff  <= side1_ff.link_length * st_ff;
         ct2_ff   <= ct_ff;
         st2_ff   <= st_ff;
         ca2_ff   <= ca_ff;
         sa2_ff   <= sa_ff;
         side2_ff <= side1_ff;
         rsp_ff   <= rsp_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_data  = rsp_ff;

endmodule

FILE: src/dh_link_transform.sv
`timescale 1ns / 1ps
// throughput: one request per cycle; the whole pipeline holds while a result
// waits under rsp_stall, so nothing is dropped or repeated
// reset: synchronous, clears every stage valid bit; payload is not reset
// ----------------------------------------------------------------------------
// dh_link_transform
// Denavit-Hartenberg link transform: rotation entries and translation of one
// link per request, via two pipelined cordic lanes and a product stage.
// ----------------------------------------------------------------------------
module dh_link_transform (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dhlt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dhlt_pkg::rsp_type rsp_data
);
   import dhlt_pkg::*;

   logic     enable;
   logic     prep_valid, cord_valid;
   cord_type prep_theta, prep_alpha, cord_theta, cord_alpha;
   side_type prep_side, cord_side;

   // advance unless a finished result is being held back
   assign enable    = !(rsp_valid && rsp_stall);
   assign req_stall = !enable;

   dhlt_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (prep_valid),
      .out_theta (prep_theta),
      .out_alpha (prep_alpha),
      .out_side  (prep_side)
   );

   dhlt_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (prep_valid),
      .in_theta  (prep_theta),
      .in_alpha  (prep_alpha),
      .in_side   (prep_side),
      .out_valid (cord_valid),
      .out_theta (cord_theta),
      .out_alpha (cord_alpha),
      .out_side  (cord_side)
   );

   dhlt_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (cord_valid),
      .in_theta  (cord_theta),
      .in_alpha  (cord_alpha),
      .in_side   (cord_side),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output");
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.rot_22 <= 32'sd1100000000)
                 && (rsp_data.rot_22 >= -32'sd1100000000)
                 && (rsp_data.rot_00 <= 32'sd1100000000)
                 && (rsp_data.rot_00 >= -32'sd1100000000))
      else $error("cosine out of unit range");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(cord_theta) && $stable(cord_valid))
      else $error("pipeline moved during output stall");
`endif

endmodule
